### src/psf_pkg.sv
package psf_pkg;

  // Frame layout and limits
  localparam logic [8:0] MIN_FRAME  = 9'd34;
  localparam logic [3:0] MIN_WORDS  = 4'd5;
  localparam logic [7:0] TYPE_HIGH  = 8'h08;
  localparam logic [7:0] TYPE_LOW   = 8'h00;
  localparam logic [7:0] PROTO_TCP  = 8'h06;
  localparam int unsigned TABLE_CAP = 1000;

  // Table search lanes: entries compared per cycle
  localparam int unsigned LANES  = 8;
  localparam int unsigned LANE_W = 3;

  // Verdict cause codes
  typedef enum logic [2:0] {
    CAUSE_NONE      = 3'd0,
    CAUSE_BLACKLIST = 3'd1,
    CAUSE_UNION     = 3'd2,
    CAUSE_SCRIPT    = 3'd3,
    CAUSE_SHELL     = 3'd4
  } cause_e;

  // Signature text: "UNION SELECT", "<script>", "; /bin/"
  localparam int unsigned SIG_NUM = 3;
  localparam logic [7:0] SIG_TEXT [SIG_NUM][12] = '{
    '{8'h55, 8'h4E, 8'h49, 8'h4F, 8'h4E, 8'h20, 8'h53, 8'h45, 8'h4C, 8'h45, 8'h43, 8'h54},
    '{8'h3C, 8'h73, 8'h63, 8'h72, 8'h69, 8'h70, 8'h74, 8'h3E, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h3B, 8'h20, 8'h2F, 8'h62, 8'h69, 8'h6E, 8'h2F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };
  localparam logic [3:0] SIG_LEN [SIG_NUM] = '{4'd12, 4'd8, 4'd7};
  localparam logic [8:0] SIG_SPAN = 9'd12;

  // Header fields of the frame as of the current beat
  typedef struct packed {
    logic        ipv4;
    logic        tcp;
    logic [3:0]  ihl;
    logic [3:0]  doff;
    logic [2:0]  alive;
    logic [31:0] src;
    logic [8:0]  len;
  } hdr_t;

  // Control into the blacklist table
  typedef struct packed {
    logic start;
    logic record;
  } lk_ctl_t;

  // Status from the blacklist table
  typedef struct packed {
    logic busy;
    logic hit;
    logic room;
  } lk_stat_t;

endpackage

### src/packet_signature_filter.sv
// The verdict is in the output register in the cycle after the final beat is taken.
// Throughput: one frame byte per cycle. The final beat is held off while the blacklist
// scan runs and while a stalled verdict still sits in the output register. The scan starts
// after byte 30 and covers the n stored sources, eight lane RAMs compared per cycle,
// with at most 1000 entries.
// Reset: asynchronous; clears frame state, scan control and the fill count, not table RAM.
module packet_signature_filter #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  frame_byte_i,
  input  logic        frame_end_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        drop_o,
  output logic [2:0]  cause_o,
  output logic [31:0] source_address_o,
  output logic        newly_recorded_o
);

  localparam int unsigned LIMIT =
    (TABLE_DEPTH < psf_pkg::TABLE_CAP) ? TABLE_DEPTH : psf_pkg::TABLE_CAP;

  psf_pkg::hdr_t     hdr;
  psf_pkg::lk_ctl_t  lk_ctl;
  psf_pkg::lk_stat_t lk_stat;
  logic [31:0]       src_q;
  logic              start;

  logic out_valid_q;
  logic out_free, beat, fin;

  logic              drop_d, drop_q;
  psf_pkg::cause_e   cause_d, cause_q;
  logic [31:0]       src_d, src_out_q;
  logic              rec_d, rec_q;
  logic [8:0]        need_tcp, need_pay;

  // Handshake: only the final beat waits on the scan or the output register
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = frame_end_i && (lk_stat.busy || !out_free);
  assign beat       = in_valid_i && !in_stall_o;
  assign fin        = beat && frame_end_i;

  psf_parse u_parse (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .beat_i  (beat),
    .byte_i  (frame_byte_i),
    .last_i  (frame_end_i),
    .hdr_o   (hdr),
    .src_o   (src_q),
    .start_o (start)
  );

  assign lk_ctl.start  = start;
  assign lk_ctl.record = fin && rec_d;

  psf_lookup #(
    .TABLE_LIMIT (LIMIT)
  ) u_lookup (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (lk_ctl),
    .src_i  (src_q),
    .stat_o (lk_stat)
  );

  // Verdict on the final beat
  always_comb begin
    need_tcp = 9'd34 + {3'b000, hdr.ihl, 2'b00};
    need_pay = 9'd26 + {3'b000, hdr.ihl, 2'b00} + {3'b000, hdr.doff, 2'b00};
    drop_d   = 1'b0;
    cause_d  = psf_pkg::CAUSE_NONE;
    src_d    = '0;
    rec_d    = 1'b0;
    if (hdr.ipv4 && hdr.len >= psf_pkg::MIN_FRAME) begin
      src_d = hdr.src;
      if (lk_stat.hit) begin
        drop_d  = 1'b1;
        cause_d = psf_pkg::CAUSE_BLACKLIST;
      end else if (hdr.tcp && hdr.ihl >= psf_pkg::MIN_WORDS && hdr.len >= need_tcp &&
                   hdr.doff >= psf_pkg::MIN_WORDS && hdr.len >= need_pay) begin
        if (hdr.alive[0]) begin
          drop_d  = 1'b1;
          cause_d = psf_pkg::CAUSE_UNION;
        end else if (hdr.alive[1]) begin
          drop_d  = 1'b1;
          cause_d = psf_pkg::CAUSE_SCRIPT;
        end else if (hdr.alive[2]) begin
          drop_d  = 1'b1;
          cause_d = psf_pkg::CAUSE_SHELL;
        end
        rec_d = drop_d && lk_stat.room;
      end
    end
  end

  // Output register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (fin) begin
      drop_q    <= drop_d;
      cause_q   <= cause_d;
      src_out_q <= src_d;
      rec_q     <= rec_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign drop_o           = drop_q;
  assign cause_o          = cause_q;
  assign source_address_o = src_out_q;
  assign newly_recorded_o = rec_q;

  // Every final beat yields a verdict beat
  a_fin_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin |=> out_valid_o)
    else $error("verdict missing after final beat");

  // A recorded source always comes with a signature drop
  a_rec_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && newly_recorded_o) |->
      (drop_o && cause_o != psf_pkg::CAUSE_BLACKLIST && cause_o != psf_pkg::CAUSE_NONE))
    else $error("record without signature drop");

  // Final beat never taken while the scan is still running
  a_fin_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin |-> !lk_stat.busy)
    else $error("final beat taken during scan");

endmodule

### src/psf_ram.sv
module psf_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### src/psf_parse.sv
module psf_parse (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              beat_i,
  input  logic [7:0]        byte_i,
  input  logic              last_i,
  output psf_pkg::hdr_t     hdr_o,
  output logic [31:0]       src_o,
  output logic              start_o
);

  localparam logic [7:0] POS_TYPE_HI = 8'd12;
  localparam logic [7:0] POS_TYPE_LO = 8'd13;
  localparam logic [7:0] POS_IHL     = 8'd14;
  localparam logic [7:0] POS_PROTO   = 8'd23;
  localparam logic [7:0] POS_SRC_LO  = 8'd26;
  localparam logic [7:0] POS_SRC_HI  = 8'd29;

  logic [7:0]  pos_q, pos_d;
  logic        type_hi_q, type_hi_d;
  logic        ipv4_q, ipv4_d;
  logic        tcp_q, tcp_d;
  logic [3:0]  ihl_q, ihl_d;
  logic [3:0]  doff_q, doff_d;
  logic [2:0]  alive_q, alive_d;
  logic [31:0] src_q, src_d;

  logic [8:0]  pos_w, tcp_start, off_pos, pay_start, pay_end;
  logic [3:0]  k;

  // Field capture and signature tracking for the current byte
  always_comb begin
    pos_w     = {1'b0, pos_q};
    type_hi_d = type_hi_q;
    ipv4_d    = ipv4_q;
    tcp_d     = tcp_q;
    ihl_d     = ihl_q;
    doff_d    = doff_q;
    alive_d   = alive_q;
    src_d     = src_q;

    if (pos_q == POS_TYPE_HI) type_hi_d = (byte_i == psf_pkg::TYPE_HIGH);
    if (pos_q == POS_TYPE_LO) ipv4_d = type_hi_q && (byte_i == psf_pkg::TYPE_LOW);
    if (pos_q == POS_IHL) ihl_d = byte_i[3:0];
    if (pos_q == POS_PROTO) tcp_d = (byte_i == psf_pkg::PROTO_TCP);
    if (pos_q >= POS_SRC_LO && pos_q <= POS_SRC_HI) src_d = {src_q[23:0], byte_i};

    tcp_start = 9'd14 + {3'b000, ihl_d, 2'b00};
    off_pos   = tcp_start + 9'd12;
    if (pos_w == off_pos) doff_d = byte_i[7:4];
    pay_start = tcp_start + {3'b000, doff_d, 2'b00};
    pay_end   = pay_start + psf_pkg::SIG_SPAN;
    k         = 4'(pos_w - pay_start);

    if (pos_w > off_pos && pos_w >= pay_start && pos_w < pay_end) begin
      for (int i = 0; i < psf_pkg::SIG_NUM; i++) begin
        if (k < psf_pkg::SIG_LEN[i] && byte_i != psf_pkg::SIG_TEXT[i][k]) begin
          alive_d[i] = 1'b0;
        end
      end
    end

    pos_d = (pos_q == 8'hFF) ? pos_q : pos_q + 8'd1;
  end

  // Frame state; cleared after the final beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      type_hi_q <= 1'b0;
      ipv4_q    <= 1'b0;
      tcp_q     <= 1'b0;
      ihl_q     <= '0;
      doff_q    <= '0;
      alive_q   <= 3'b111;
      src_q     <= '0;
    end else if (beat_i) begin
      if (last_i) begin
        pos_q     <= '0;
        type_hi_q <= 1'b0;
        ipv4_q    <= 1'b0;
        tcp_q     <= 1'b0;
        ihl_q     <= '0;
        doff_q    <= '0;
        alive_q   <= 3'b111;
        src_q     <= '0;
      end else begin
        pos_q     <= pos_d;
        type_hi_q <= type_hi_d;
        ipv4_q    <= ipv4_d;
        tcp_q     <= tcp_d;
        ihl_q     <= ihl_d;
        doff_q    <= doff_d;
        alive_q   <= alive_d;
        src_q     <= src_d;
      end
    end
  end

  assign hdr_o.ipv4  = ipv4_d;
  assign hdr_o.tcp   = tcp_d;
  assign hdr_o.ihl   = ihl_d;
  assign hdr_o.doff  = doff_d;
  assign hdr_o.alive = alive_d;
  assign hdr_o.src   = src_d;
  assign hdr_o.len   = pos_w + 9'd1;

  assign src_o   = src_q;
  // Source address complete: kick off the table scan
  assign start_o = beat_i && !last_i && (pos_q == POS_SRC_HI);

endmodule

### src/psf_lookup.sv
module psf_lookup #(
  parameter int unsigned TABLE_LIMIT = 1000
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  psf_pkg::lk_ctl_t   ctl_i,
  input  logic [31:0]        src_i,
  output psf_pkg::lk_stat_t  stat_o
);

  localparam int unsigned LANES = psf_pkg::LANES;
  localparam int unsigned LW    = psf_pkg::LANE_W;
  localparam int unsigned ROWS  = (TABLE_LIMIT + LANES - 1) / LANES;
  localparam int unsigned AW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned CW    = $clog2(TABLE_LIMIT + LANES);

  logic [CW-1:0] used_q, used_d;
  logic [AW-1:0] rd_row_q, rd_row_d;
  logic [AW-1:0] pend_row_q, pend_row_d;
  logic          issue_q, issue_d;
  logic          pend_q, pend_d;
  logic          hit_q, hit_d;

  logic [AW-1:0] wr_row, last_row;
  logic [LW-1:0] wr_lane;
  logic [31:0]   rdata [LANES];
  logic [LANES-1:0] match;

  assign wr_row   = AW'(used_q >> LW);
  assign wr_lane  = used_q[LW-1:0];
  assign last_row = AW'((used_q - CW'(1)) >> LW);

  // One RAM per lane; entry i sits in lane i mod LANES, row i / LANES
  for (genvar l = 0; l < LANES; l++) begin : g_lane
    psf_ram #(
      .WIDTH (32),
      .DEPTH (ROWS)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (ctl_i.record && (wr_lane == LW'(l))),
      .waddr_i (wr_row),
      .wdata_i (src_i),
      .raddr_i (rd_row_q),
      .rdata_o (rdata[l])
    );
  end

  // Compare the returned row against the source; only filled entries count
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      match[l] = pend_q && (((CW'(pend_row_q) << LW) | CW'(l)) < used_q)
                 && (rdata[l] == src_i);
    end
  end

  // Scan sequencer: one row read per cycle, compare in the next cycle
  always_comb begin
    issue_d    = issue_q;
    rd_row_d   = rd_row_q;
    pend_d     = 1'b0;
    pend_row_d = pend_row_q;
    hit_d      = hit_q | (|match);
    used_d     = used_q;

    if (ctl_i.start) begin
      issue_d  = (used_q != '0);
      rd_row_d = '0;
      hit_d    = 1'b0;
    end else if (issue_q) begin
      pend_d     = 1'b1;
      pend_row_d = rd_row_q;
      if (rd_row_q == last_row) begin
        issue_d = 1'b0;
      end else begin
        rd_row_d = rd_row_q + AW'(1);
      end
    end

    if (ctl_i.record) used_d = used_q + CW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q     <= '0;
      rd_row_q   <= '0;
      pend_row_q <= '0;
      issue_q    <= 1'b0;
      pend_q     <= 1'b0;
      hit_q      <= 1'b0;
    end else begin
      used_q     <= used_d;
      rd_row_q   <= rd_row_d;
      pend_row_q <= pend_row_d;
      issue_q    <= issue_d;
      pend_q     <= pend_d;
      hit_q      <= hit_d;
    end
  end

  assign stat_o.busy = issue_q || pend_q;
  assign stat_o.hit  = hit_q;
  assign stat_o.room = (used_q < CW'(TABLE_LIMIT));

  // A new entry must never land while a scan is running
  a_no_record_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.record |-> !(issue_q || pend_q))
    else $error("table write during scan");

  // Fill count stays within the table limit
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.record |=> (used_q <= CW'(TABLE_LIMIT)) && (used_q == $past(used_q) + CW'(1)))
    else $error("fill count out of range");

  // A scan over a non-empty table issues reads right after start
  a_scan_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.start && used_q != '0) |=> issue_q && !hit_q)
    else $error("scan did not start");

endmodule

### verif/packet_signature_filter_tb.sv
module packet_signature_filter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Frame layout as the filter sees it
  localparam logic [15:0] ETH_IPV4      = 16'h0800;
  localparam logic [7:0]  IP_PROTO_TCP  = 8'd6;
  localparam logic [7:0]  IP_PROTO_UDP  = 8'd17;
  localparam int unsigned FRAME_MIN_LEN = 34;
  localparam int unsigned MATCH_SPAN    = 12;
  localparam int unsigned TABLE_ROOM    = 1000;

  // Signatures, left aligned, one byte per character
  localparam int SIG_UNION  = 0;
  localparam int SIG_SCRIPT = 1;
  localparam int SIG_SHELL  = 2;
  localparam int SIG_NONE   = 3;
  localparam int NO_FLIP    = -1;
  localparam logic [95:0] SIG_BYTES [3] = '{
    "UNION SELECT", {"<script>", 32'h0}, {"; /bin/", 40'h0}
  };
  localparam int SIG_CHARS [3] = '{12, 8, 7};
  localparam psf_pkg::cause_e MATCH_CAUSE [3] =
    '{psf_pkg::CAUSE_UNION, psf_pkg::CAUSE_SCRIPT, psf_pkg::CAUSE_SHELL};

  // Run shape
  localparam int POOL_SIZE   = 12;
  localparam int RAND_BYTES  = 100;
  localparam int RAND_FRAMES = 2;
  localparam int CALM_LO     = 800;
  localparam int CALM_HI     = 1200;
  localparam int HOLD_A      = 300;
  localparam int HOLD_B      = 1600;
  localparam int HOLD_LEN    = 300;
  localparam int TAIL_CYCLES = 20;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } beat_t;

  typedef struct {
    logic            drop;
    psf_pkg::cause_e cause;
    logic [31:0]     src;
    logic            rec;
  } verdict_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  frame_byte = 8'h00;
  logic        frame_end = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        drop;
  logic [2:0]  cause;
  logic [31:0] source_address;
  logic        newly_recorded;

  packet_signature_filter uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .frame_byte_i     (frame_byte),
    .frame_end_i      (frame_end),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .drop_o           (drop),
    .cause_o          (cause),
    .source_address_o (source_address),
    .newly_recorded_o (newly_recorded)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  beat_t       beats[$];
  beat_t       next_beat;
  verdict_t    verdicts_due[$];
  verdict_t    seen_verdict;
  logic [31:0] listed_sources[$];
  logic [31:0] src_pool [POOL_SIZE];
  int unsigned mismatches = 0;
  int unsigned cyc;
  int unsigned hold_left;
  logic        calm;

  // Per-frame state of the filter model
  logic [7:0]  pos_q;
  logic        type_hi_q;
  logic        ipv4_q;
  logic        tcp_q;
  logic [31:0] src_q;
  logic [3:0]  ihl_q;
  logic [3:0]  doff_q;
  logic [2:0]  alive_q;

  function automatic logic [7:0] sig_char(int s, int k);
    return SIG_BYTES[s][95 - 8*k -: 8];
  endfunction

  function automatic void clear_frame();
    pos_q     = 8'd0;
    type_hi_q = 1'b0;
    ipv4_q    = 1'b0;
    tcp_q     = 1'b0;
    src_q     = 32'd0;
    ihl_q     = 4'd0;
    doff_q    = 4'd0;
    alive_q   = 3'b111;
  endfunction

  // Advance the filter model by one frame byte; a final byte yields a verdict
  function automatic void filter_byte(input logic [7:0] b, input logic last);
    int unsigned tcp_at, pay_at, len, k, i;
    logic        listed;
    verdict_t    v;
    if (pos_q == 8'd12) type_hi_q = (b == ETH_IPV4[15:8]);
    if (pos_q == 8'd13) ipv4_q = type_hi_q && (b == ETH_IPV4[7:0]);
    if (pos_q == 8'd14) ihl_q = b[3:0];
    if (pos_q == 8'd23) tcp_q = (b == IP_PROTO_TCP);
    if (pos_q >= 8'd26 && pos_q <= 8'd29) src_q = {src_q[23:0], b};
    tcp_at = 14 + 4 * ihl_q;
    if (pos_q == tcp_at + 12) doff_q = b[7:4];
    pay_at = tcp_at + 4 * doff_q;
    // A signature drops out at its first differing payload byte
    if (pos_q > tcp_at + 12 && pos_q >= pay_at && pos_q < pay_at + MATCH_SPAN) begin
      k = pos_q - pay_at;
      for (i = 0; i < 3; i++) begin
        if (k < SIG_CHARS[i] && b != sig_char(i, k)) alive_q[i] = 1'b0;
      end
    end
    if (!last) begin
      if (pos_q != 8'hFF) pos_q = pos_q + 8'd1;
      return;
    end

    len    = pos_q + 1;
    v.drop = 1'b0;
    v.cause = psf_pkg::CAUSE_NONE;
    v.src  = 32'd0;
    v.rec  = 1'b0;
    if (ipv4_q && len >= FRAME_MIN_LEN) begin
      v.src  = src_q;
      listed = 1'b0;
      for (i = 0; i < listed_sources.size(); i++) begin
        if (listed_sources[i] == src_q) listed = 1'b1;
      end
      if (listed) begin
        v.drop  = 1'b1;
        v.cause = psf_pkg::CAUSE_BLACKLIST;
      end else if (tcp_q && ihl_q >= 4'd5 && len >= tcp_at + 20 && doff_q >= 4'd5 &&
                   len >= pay_at + MATCH_SPAN) begin
        for (i = 0; i < 3; i++) begin
          if (alive_q[i] && !v.drop) begin
            v.drop  = 1'b1;
            v.cause = MATCH_CAUSE[i];
          end
        end
        // A full table still drops, it just records nothing
        if (v.drop && listed_sources.size() < TABLE_ROOM) begin
          listed_sources.push_back(src_q);
          v.rec = 1'b1;
        end
      end
    end
    verdicts_due.push_back(v);
    clear_frame();
  endfunction

  // Build one frame and queue its beats; sig picks the payload, flip corrupts one byte
  task automatic queue_frame(input logic [15:0] etype, input logic [7:0] proto,
                             input logic [3:0] ihl, input logic [3:0] doff,
                             input logic [31:0] src, input int sig, input int flip,
                             input int flen);
    logic [7:0]  fr [400];
    int unsigned tcp_at, pay_at;
    int          i;
    beat_t       bt;
    for (i = 0; i < 400; i++) fr[i] = 8'($urandom);
    tcp_at = 14 + 4 * ihl;
    pay_at = tcp_at + 4 * doff;
    fr[12] = etype[15:8];
    fr[13] = etype[7:0];
    fr[14] = {4'h4, ihl};
    fr[23] = proto;
    fr[26] = src[31:24];
    fr[27] = src[23:16];
    fr[28] = src[15:8];
    fr[29] = src[7:0];
    fr[tcp_at + 12] = {doff, fr[tcp_at + 12][3:0]};
    if (sig != SIG_NONE) begin
      for (i = 0; i < SIG_CHARS[sig]; i++) fr[pay_at + i] = sig_char(sig, i);
      if (flip != NO_FLIP) fr[pay_at + flip] = fr[pay_at + flip] ^ 8'h20;
    end
    for (i = 0; i < flen; i++) begin
      bt.data = fr[i];
      bt.last = (i == flen - 1);
      beats.push_back(bt);
    end
  endtask

  // One random frame, mostly well formed TCP with a signature; returns its length
  task automatic queue_random_frame(output int flen);
    int          r, sig, flip, pay_at;
    logic [15:0] etype;
    logic [7:0]  proto;
    logic [3:0]  ihl, doff;
    logic [31:0] src;
    r     = $urandom_range(99);
    etype = ETH_IPV4;
    proto = IP_PROTO_TCP;
    src   = src_pool[$urandom_range(POOL_SIZE - 1)];
    r     = $urandom_range(99);
    ihl   = (r < 80) ? 4'd5 : (r < 95) ? 4'($urandom_range(6, 15)) : 4'($urandom_range(4));
    r     = $urandom_range(99);
    doff  = (r < 80) ? 4'd5 : (r < 95) ? 4'($urandom_range(6, 15)) : 4'($urandom_range(4));
    r     = $urandom_range(99);
    sig   = (r < 25) ? SIG_UNION : (r < 45) ? SIG_SCRIPT : (r < 65) ? SIG_SHELL : SIG_NONE;
    flip  = NO_FLIP;
    if (sig != SIG_NONE && $urandom_range(9) == 0) flip = $urandom_range(SIG_CHARS[sig] - 1);
    pay_at = 14 + 4 * ihl + 4 * doff;
    r      = $urandom_range(99);
    if (r < 80) flen = pay_at + 12 + $urandom_range(16);
    else if (r < 90) flen = pay_at + 11;
    else flen = $urandom_range(FRAME_MIN_LEN, pay_at + 11);
    if ($urandom_range(49) == 0) flen = $urandom_range(257, 300);

    // Kind of frame: TCP, other protocol, other ethertype, runt
    r = $urandom_range(99);
    if (r >= 65 && r < 75) begin
      proto = ($urandom_range(1) == 0) ? IP_PROTO_UDP : 8'($urandom);
      if (proto == IP_PROTO_TCP) proto = IP_PROTO_UDP;
    end else if (r >= 75 && r < 85) begin
      case ($urandom_range(3))
        0: etype = {ETH_IPV4[15:8], 8'($urandom_range(1, 255))};
        1: etype = {8'($urandom_range(9, 255)), ETH_IPV4[7:0]};
        default: etype = 16'($urandom);
      endcase
      if (etype == ETH_IPV4) etype = 16'h86DD;
    end else if (r >= 85) begin
      flen = $urandom_range(1, FRAME_MIN_LEN - 1);
    end
    queue_frame(etype, proto, ihl, doff, src, sig, flip, flen);
  endtask

  // Cycle count, calm window and long receiver hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cyc       <= 0;
      hold_left <= 0;
    end else begin
      cyc <= cyc + 1;
      if (cyc == HOLD_A || cyc == HOLD_B) begin
        hold_left <= HOLD_LEN;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end
    end
  end

  assign calm = (cyc >= CALM_LO) && (cyc < CALM_HI);

  // Driver: offer frame bytes, feed the model on each accepted beat
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid   <= 1'b0;
      frame_byte <= 8'h00;
      frame_end  <= 1'b0;
    end else begin
      if (in_valid && !in_stall) filter_byte(frame_byte, frame_end);
      if (!in_valid || !in_stall) begin
        if (beats.size() != 0 && (calm || $urandom_range(99) >= 22)) begin
          next_beat   = beats.pop_front();
          in_valid   <= 1'b1;
          frame_byte <= next_beat.data;
          frame_end  <= next_beat.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each taken verdict with the oldest one due
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (verdicts_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%t: unexpected verdict drop=%0d cause=%0d src=%h rec=%0d",
                     $realtime, drop, cause, source_address, newly_recorded);
        end else begin
          seen_verdict = verdicts_due.pop_front();
          if (drop !== seen_verdict.drop || cause !== seen_verdict.cause ||
              source_address !== seen_verdict.src || newly_recorded !== seen_verdict.rec) begin
            mismatches++;
            if (mismatches <= 10) begin
              $write("%t: verdict mismatch exp drop=%0d cause=%0d src=%h rec=%0d",
                     $realtime, seen_verdict.drop, seen_verdict.cause, seen_verdict.src,
                     seen_verdict.rec);
              $display(" got drop=%0d cause=%0d src=%h rec=%0d",
                       drop, cause, source_address, newly_recorded);
            end
          end
        end
      end
      out_stall <= (hold_left != 0) || (!calm && $urandom_range(99) < 22);
    end
  end

  // Stimulus and end of run
  initial begin
    int sent_bytes, sent_frames, flen, n;
    clear_frame();
    src_pool[0] = 32'h0000_0000;
    src_pool[1] = 32'hFFFF_FFFF;
    for (n = 2; n < POOL_SIZE; n++) src_pool[n] = $urandom;

    // Directed: runts, foreign ethertypes, header limits, each signature
    queue_frame(ETH_IPV4, IP_PROTO_TCP, 4'd5, 4'd5, src_pool[2], SIG_UNION, NO_FLIP, 1);
    queue_frame(ETH_IPV4, IP_PROTO_TCP, 4'd5, 4'd5, src_pool[2], SIG_UNION, NO_FLIP, 33);
    queue_frame(ETH_IPV4, IP_PROTO_TCP, 4'd5, 4'd5, src_pool[2], SIG_UNION, NO_FLIP, 34);
    queue_frame(16'h86DD, IP_PROTO_TCP, 4'd5, 4'd5, src_pool[2], SIG_UNION, NO_FLIP, 40);
    queue_frame(16'h0801, IP_PROTO_TCP, 4'd5, 4'd5, src_pool[2], SIG_UNION, NO_FLIP, 40);
    queue_frame(16'h0900, IP_PROTO_TCP, 4'd5, 4'd5, src_pool[2], SIG_UNION, NO_FLIP, 40);
    queue_frame(ETH_IPV4, IP_PROTO_UDP, 4'd5, 4'd5, src_pool[2], SIG_UNION, NO_FLIP, 40);
    queue_frame(ETH_IPV4, IP_PROTO_TCP, 4'd4, 4'd5, src_pool[2], SIG_UNION, NO_FLIP, 40);
    queue_frame(ETH_IPV4, IP_PROTO_TCP, 4'd0, 4'd5, src_pool[2], SIG_UNION, NO_FLIP, 40);
    queue_frame(ETH_IPV4, IP_PROTO_TCP, 4'd5, 4'd5, src_pool[2], SIG_UNION, NO_FLIP, 53);
    queue_frame(ETH_IPV4, IP_PROTO_TCP, 4'd5, 4'd4, src_pool[2], SIG_UNION, NO_FLIP, 56);
    queue_frame(ETH_IPV4, IP_PROTO_TCP, 4'd5, 4'd0, src_pool[2], SIG_UNION, NO_FLIP, 56);
    queue_frame(ETH_IPV4, IP_PROTO_TCP, 4'd5, 4'd5, src_pool[2], SIG_UNION, NO_FLIP, 65);
    queue_frame(ETH_IPV4, IP_PROTO_TCP, 4'd5, 4'd5, src_pool[2], SIG_UNION, NO_FLIP, 66);
    queue_frame(ETH_IPV4, IP_PROTO_TCP, 4'd5, 4'd5, src_pool[3], SIG_SCRIPT, NO_FLIP, 66);
    queue_frame(ETH_IPV4, IP_PROTO_TCP, 4'd5, 4'd5, src_pool[4], SIG_SHELL, NO_FLIP, 70);
    // Recorded source comes back: blacklist wins over everything else
    queue_frame(ETH_IPV4, IP_PROTO_TCP, 4'd5, 4'd5, src_pool[2], SIG_NONE, NO_FLIP, 80);
    queue_frame(ETH_IPV4, IP_PROTO_TCP, 4'd5, 4'd5, src_pool[3], SIG_UNION, NO_FLIP, 66);
    // Near misses on the last character of two signatures and the first of the third
    queue_frame(ETH_IPV4, IP_PROTO_TCP, 4'd5, 4'd5, src_pool[5], SIG_UNION, 11, 66);
    queue_frame(ETH_IPV4, IP_PROTO_TCP, 4'd5, 4'd5, src_pool[5], SIG_SCRIPT, 7, 66);
    queue_frame(ETH_IPV4, IP_PROTO_TCP, 4'd5, 4'd5, src_pool[5], SIG_SHELL, 0, 66);
    // Largest headers, a frame past the position counter's range, extreme sources
    queue_frame(ETH_IPV4, IP_PROTO_TCP, 4'd15, 4'd15, src_pool[6], SIG_SHELL, NO_FLIP, 146);
    queue_frame(ETH_IPV4, IP_PROTO_TCP, 4'd5, 4'd5, src_pool[7], SIG_UNION, NO_FLIP, 300);
    queue_frame(ETH_IPV4, IP_PROTO_TCP, 4'd5, 4'd5, src_pool[0], SIG_UNION, NO_FLIP, 66);
    queue_frame(ETH_IPV4, IP_PROTO_TCP, 4'd5, 4'd5, src_pool[1], SIG_SCRIPT, NO_FLIP, 67);

    // Random frames over a small source pool so sources repeat
    sent_bytes  = 0;
    sent_frames = 0;
    while (sent_bytes < RAND_BYTES || sent_frames < RAND_FRAMES) begin
      queue_random_frame(flen);
      sent_bytes += flen;
      sent_frames++;
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (beats.size() != 0 || in_valid || verdicts_due.size() != 0) begin
      @(posedge clk_i);
      #1;
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && verdicts_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #1_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
